>>> rtl/core/pid_position_controller_top_defines.svh
// Assertion macros for the checker of the PID position controller.
// Depends on nothing; included by the checker next to the top level.
`ifndef PID_POSITION_CONTROLLER_TOP_DEFINES_SVH
`define PID_POSITION_CONTROLLER_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define PIDPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PIDPC_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/pidpc_pkg.sv
// Types, widths and constants of the PID position controller.
// No dependencies; the interfaces, the controller modules and the testbench import it.
package pidpc_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int FRAC_BITS       = 16;
   localparam int ACC_WIDTH       = DATA_WIDTH + 2;
   localparam int SETPOINT_WIDTH  = 17;
   localparam int VOLTS_WIDTH     = 16;
   localparam int POS_WIDTH       = 17;
   localparam int STEP_WIDTH      = 31;

   // Serial multiplier: radix-16 digits of the second operand.
   localparam int DIGIT_WIDTH     = 4;
   localparam int MUL_A_WIDTH     = ACC_WIDTH;
   localparam int MUL_B_WIDTH     = 32;
   localparam int MUL_DIGITS      = MUL_B_WIDTH / DIGIT_WIDTH;
   localparam int MUL_CNT_WIDTH   = $clog2(MUL_DIGITS);
   localparam int MUL_ACC_WIDTH   = MUL_A_WIDTH + DIGIT_WIDTH + 1;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_P    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_I    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_D    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_TIME = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_STEP  = 3'd4;

   localparam logic signed [DATA_WIDTH-1:0] GAIN_P_RESET    = 32'sd45875;
   localparam logic signed [DATA_WIDTH-1:0] GAIN_I_RESET    = 32'sd13107;
   localparam logic signed [DATA_WIDTH-1:0] GAIN_D_RESET    = 32'sd19661;
   localparam logic [STEP_WIDTH-1:0]        STEP_TIME_RESET = 31'd655;
   localparam logic [STEP_WIDTH-1:0]        INV_STEP_RESET  = 31'd6553600;

   // Sensor window of 2 V to 8 V in Q4.12. Inside it the position is
   // floor((raw + 2048) * 16 / 25), done as a multiply by ceil(2^25 / 25)
   // followed by a drop of 25 bits (16 in the multiplier, 9 afterwards).
   localparam logic [VOLTS_WIDTH-1:0] VOLTS_LOW    = 16'd8192;
   localparam logic [VOLTS_WIDTH-1:0] VOLTS_HIGH   = 16'd32768;
   localparam logic [VOLTS_WIDTH-1:0] VOLTS_OFFSET = 16'd2048;
   localparam int                     POS_PRE_SHIFT  = 4;
   localparam int                     POS_POST_SHIFT = 9;
   localparam logic [MUL_B_WIDTH-1:0] POS_RECIP    = 32'd1342178;
   localparam logic [POS_WIDTH-1:0]   POS_FULL     = 17'd65536;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] gain_p;
      logic signed [DATA_WIDTH-1:0] gain_i;
      logic signed [DATA_WIDTH-1:0] gain_d;
      logic [STEP_WIDTH-1:0]        step_time;
      logic [STEP_WIDTH-1:0]        inverse_step_time;
   } cfg_type;

   typedef struct packed {
      logic                          start;
      logic signed [MUL_A_WIDTH-1:0] a;
      logic signed [MUL_B_WIDTH-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                         done;
      logic signed [DATA_WIDTH-1:0] result;
   } mul_rsp_type;

   typedef struct packed {
      logic                         valid;
      logic signed [DATA_WIDTH-1:0] drive;
      logic [POS_WIDTH-1:0]         measured_position;
      logic                         retract;
   } result_type;

   function automatic logic signed [ACC_WIDTH-1:0] widen(
      input logic signed [DATA_WIDTH-1:0] x);
      return {{(ACC_WIDTH-DATA_WIDTH){x[DATA_WIDTH-1]}}, x};
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_data(
      input logic signed [ACC_WIDTH-1:0] x);
      logic [ACC_WIDTH-DATA_WIDTH:0] hi_bits;
      hi_bits = x[ACC_WIDTH-1:DATA_WIDTH-1];
      if ((&hi_bits) || (~|hi_bits)) begin
         return x[DATA_WIDTH-1:0];
      end else if (x[ACC_WIDTH-1]) begin
         return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
   endfunction

endpackage

>>> rtl/core/pidpc_if.sv
// Valid/ready channel interfaces for requests and results of the controller.
// Depends on pidpc_pkg for the payload widths.
interface pidpc_req_if;
   import pidpc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [SETPOINT_WIDTH-1:0] setpoint;
   logic [VOLTS_WIDTH-1:0]    sensor_volts;

   modport source (output valid, output setpoint, output sensor_volts, input ready);
   modport sink   (input valid, input setpoint, input sensor_volts, output ready);
endinterface

interface pidpc_rsp_if;
   import pidpc_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] drive;
   logic [POS_WIDTH-1:0]         measured_position;
   logic                         retract;

   modport source (output valid, output drive, output measured_position,
                   output retract, input ready);
   modport sink   (input valid, input drive, input measured_position,
                   input retract, output ready);
endinterface

>>> rtl/core/pid_position_controller_top.sv
// PID position controller: gain registers, tick sequencer, serial multiplier
// and result register. Depends on pidpc_pkg, pidpc_if, pidpc_sequencer and
// pidpc_serial_mul.
//
// Each request on req carries a setpoint fraction and a raw sensor voltage.
// Each request gives exactly one result on rsp: the saturated drive, the
// measured position and the retract flag.
// A request is worked through six products, one after another, on one
// radix-16 serial multiplier. The csr port writes the gain or step time
// that csr_index selects, while csr_wr_en is high.
// req.ready is high only while no request is in work; it does not wait for
// rsp, because the result register holds the previous result meanwhile.
// If rsp still holds an untaken result when the next one is finished, the
// new result and req.ready both wait until rsp.ready frees the register.
// The user must write the csr port only while the block is idle; the block
// itself does not enforce this. Synchronous reset empties the result
// register, restores the register defaults and clears the integral,
// previous error and last drive.
module pid_position_controller_top (
   input  logic                                 clock,
   input  logic                                 reset,
   pidpc_req_if.sink                            req,
   pidpc_rsp_if.source                          rsp,
   input  logic                                 csr_wr_en,
   input  logic [pidpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pidpc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import pidpc_pkg::*;

   cfg_type                      cfg_ff;
   mul_req_type                  mul_req;
   mul_rsp_type                  mul_rsp;
   result_type                   result;
   logic                         result_ready;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_drive_ff;
   logic [POS_WIDTH-1:0]         rsp_pos_ff;
   logic                         rsp_retract_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p            <= GAIN_P_RESET;
         cfg_ff.gain_i            <= GAIN_I_RESET;
         cfg_ff.gain_d            <= GAIN_D_RESET;
         cfg_ff.step_time         <= STEP_TIME_RESET;
         cfg_ff.inverse_step_time <= INV_STEP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAIN_P:    cfg_ff.gain_p            <= csr_wdata;
            CSR_GAIN_I:    cfg_ff.gain_i            <= csr_wdata;
            CSR_GAIN_D:    cfg_ff.gain_d            <= csr_wdata;
            CSR_STEP_TIME: cfg_ff.step_time         <= csr_wdata[STEP_WIDTH-1:0];
            CSR_INV_STEP:  cfg_ff.inverse_step_time <= csr_wdata[STEP_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   pidpc_sequencer u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .cfg          (cfg_ff),
      .mul_req      (mul_req),
      .mul_rsp      (mul_rsp),
      .result       (result),
      .result_ready (result_ready)
   );

   pidpc_serial_mul u_serial_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign result_ready = !rsp_valid_ff || rsp.ready;

   always_comb begin
      if (result.valid && result_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (result.valid && result_ready) begin
            rsp_drive_ff   <= result.drive;
            rsp_pos_ff     <= result.measured_position;
            rsp_retract_ff <= result.retract;
         end
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.drive             = rsp_drive_ff;
   assign rsp.measured_position = rsp_pos_ff;
   assign rsp.retract           = rsp_retract_ff;

endmodule

>>> rtl/core/pidpc_serial_mul.sv
// Digit-serial signed multiplier, four bits of the second operand per cycle,
// with a floor shift by FRAC_BITS and saturation. Depends on pidpc_pkg.
module pidpc_serial_mul (
   input  logic                     clock,
   input  logic                     reset,
   input  pidpc_pkg::mul_req_type   mul_req,
   output pidpc_pkg::mul_rsp_type   mul_rsp
);
   import pidpc_pkg::*;

   localparam int SHIFT_WIDTH = MUL_ACC_WIDTH + MUL_B_WIDTH - FRAC_BITS;

   logic signed [MUL_A_WIDTH-1:0]   a_ff;
   logic [MUL_B_WIDTH-1:0]          b_ff;
   logic signed [MUL_ACC_WIDTH-1:0] acc_ff;
   logic [MUL_B_WIDTH-1:0]          lo_ff;
   logic [MUL_CNT_WIDTH-1:0]        cnt_ff;
   logic                            busy_ff;
   logic                            fin_ff;
   logic                            done_ff;
   logic signed [DATA_WIDTH-1:0]    result_ff;

   logic                            last_digit;
   logic signed [DIGIT_WIDTH:0]     digit;
   logic signed [MUL_ACC_WIDTH-1:0] partial;
   logic signed [MUL_ACC_WIDTH-1:0] sum;
   logic [SHIFT_WIDTH-1:0]          shifted;
   logic signed [DATA_WIDTH-1:0]    sat_val;

   always_comb begin
      last_digit = (cnt_ff == MUL_CNT_WIDTH'(MUL_DIGITS - 1));
      // The top digit carries the sign of the second operand.
      digit   = {last_digit ? b_ff[DIGIT_WIDTH-1] : 1'b0, b_ff[DIGIT_WIDTH-1:0]};
      partial = a_ff * digit;
      sum     = acc_ff + partial;
      // Dropping FRAC_BITS low bits of a two's complement product is a floor.
      shifted = {acc_ff, lo_ff[MUL_B_WIDTH-1:FRAC_BITS]};
      if ((&shifted[SHIFT_WIDTH-1:DATA_WIDTH-1]) || (~|shifted[SHIFT_WIDTH-1:DATA_WIDTH-1])) begin
         sat_val = shifted[DATA_WIDTH-1:0];
      end else if (shifted[SHIFT_WIDTH-1]) begin
         sat_val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= 1'b0;
         if (mul_req.start) begin
            a_ff    <= mul_req.a;
            b_ff    <= mul_req.b;
            acc_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            acc_ff <= sum >>> DIGIT_WIDTH;
            lo_ff  <= {sum[DIGIT_WIDTH-1:0], lo_ff[MUL_B_WIDTH-1:DIGIT_WIDTH]};
            b_ff   <= b_ff >> DIGIT_WIDTH;
            cnt_ff <= cnt_ff + 1'b1;
            if (last_digit) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end
         if (fin_ff) begin
            result_ff <= sat_val;
         end
      end
   end

   assign mul_rsp.done   = done_ff;
   assign mul_rsp.result = result_ff;

endmodule

>>> rtl/core/pidpc_sequencer.sv
// Sequencer of one controller tick: sensor conversion, integral, derivative
// and the three gain products through the shared serial multiplier.
// Depends on pidpc_pkg and pidpc_req_if.
module pidpc_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   pidpc_req_if.sink              req,
   input  pidpc_pkg::cfg_type     cfg,
   output pidpc_pkg::mul_req_type mul_req,
   input  pidpc_pkg::mul_rsp_type mul_rsp,
   output pidpc_pkg::result_type  result,
   input  logic                   result_ready
);
   import pidpc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_LOAD, S_WAIT, S_DONE} state_type;
   typedef enum logic [2:0] {OP_POS, OP_INT, OP_DER, OP_PROP, OP_ITERM, OP_DTERM} op_type;

   state_type                     state_ff;
   op_type                        op_ff;
   logic [SETPOINT_WIDTH-1:0]     sp_ff;
   logic [VOLTS_WIDTH-1:0]        volts_ff;
   logic [POS_WIDTH-1:0]          pos_ff;
   logic signed [DATA_WIDTH-1:0]  err_ff;
   logic signed [DATA_WIDTH-1:0]  integral_ff;
   logic signed [DATA_WIDTH-1:0]  prev_err_ff;
   logic signed [DATA_WIDTH-1:0]  last_drive_ff;
   logic signed [DATA_WIDTH-1:0]  deriv_ff;
   logic signed [ACC_WIDTH-1:0]   acc_ff;
   logic signed [DATA_WIDTH-1:0]  drive_ff;
   logic                          retract_ff;

   logic [VOLTS_WIDTH:0]          volts_biased;
   logic [MUL_A_WIDTH-1:0]        pos_operand;
   logic [POS_WIDTH-1:0]          pos_sel;
   logic signed [DATA_WIDTH-1:0]  err_new;
   logic signed [DATA_WIDTH-1:0]  drive_new;

   always_comb begin
      volts_biased = {1'b0, volts_ff} + {1'b0, VOLTS_OFFSET};
      pos_operand  = MUL_A_WIDTH'({volts_biased, {POS_PRE_SHIFT{1'b0}}});
      if (volts_ff < VOLTS_LOW) begin
         pos_sel = '0;
      end else if (volts_ff > VOLTS_HIGH) begin
         pos_sel = POS_FULL;
      end else begin
         pos_sel = mul_rsp.result[POS_POST_SHIFT+POS_WIDTH-1:POS_POST_SHIFT];
      end
      // Setpoint and position are both small and positive, so no clipping.
      err_new   = DATA_WIDTH'(sp_ff) - DATA_WIDTH'(pos_sel);
      drive_new = sat_data(acc_ff + widen(mul_rsp.result));

      mul_req.start = (state_ff == S_LOAD);
      case (op_ff)
         OP_POS: begin
            mul_req.a = pos_operand;
            mul_req.b = POS_RECIP;
         end
         OP_INT: begin
            mul_req.a = widen(err_ff);
            mul_req.b = {1'b0, cfg.step_time};
         end
         OP_DER: begin
            mul_req.a = widen(err_ff) - widen(prev_err_ff);
            mul_req.b = {1'b0, cfg.inverse_step_time};
         end
         OP_PROP: begin
            mul_req.a = widen(err_ff);
            mul_req.b = cfg.gain_p;
         end
         OP_ITERM: begin
            mul_req.a = widen(integral_ff);
            mul_req.b = cfg.gain_i;
         end
         OP_DTERM: begin
            mul_req.a = widen(deriv_ff);
            mul_req.b = cfg.gain_d;
         end
         default: begin
            mul_req.a = '0;
            mul_req.b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= OP_POS;
         integral_ff   <= '0;
         prev_err_ff   <= '0;
         last_drive_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  sp_ff    <= req.setpoint;
                  volts_ff <= req.sensor_volts;
                  op_ff    <= OP_POS;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (mul_rsp.done) begin
                  state_ff <= S_LOAD;
                  case (op_ff)
                     OP_POS: begin
                        pos_ff <= pos_sel;
                        err_ff <= err_new;
                        op_ff  <= OP_INT;
                     end
                     OP_INT: begin
                        integral_ff <= sat_data(widen(integral_ff) + widen(mul_rsp.result));
                        op_ff       <= OP_DER;
                     end
                     OP_DER: begin
                        deriv_ff <= mul_rsp.result;
                        op_ff    <= OP_PROP;
                     end
                     OP_PROP: begin
                        acc_ff <= widen(mul_rsp.result);
                        op_ff  <= OP_ITERM;
                     end
                     OP_ITERM: begin
                        acc_ff <= acc_ff + widen(mul_rsp.result);
                        op_ff  <= OP_DTERM;
                     end
                     OP_DTERM: begin
                        drive_ff      <= drive_new;
                        retract_ff    <= (drive_new < last_drive_ff);
                        last_drive_ff <= drive_new;
                        prev_err_ff   <= err_ff;
                        state_ff      <= S_DONE;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_DONE: begin
               if (result_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req.ready                = (state_ff == S_IDLE);
   assign result.valid             = (state_ff == S_DONE);
   assign result.drive             = drive_ff;
   assign result.measured_position = pos_ff;
   assign result.retract           = retract_ff;

endmodule

>>> rtl/core/pidpc_checker.sv
// Port-level checks of the PID position controller, bound to the top level.
// Depends on pid_position_controller_top_defines.svh.
`include "pid_position_controller_top_defines.svh"

module pidpc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // A result that is not taken stays on the port.
   `PIDPC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result withdrawn before it was taken")

   // Only one request is in work at a time.
   `PIDPC_ASSERT(a_busy_after_req, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while another is in work")

   // A new result comes only out of a finished computation.
   `PIDPC_ASSERT(a_rsp_after_work, clock, reset, $rose(rsp_valid) |-> $past(!req_ready), "result appeared while the core was idle")

   // Reset leaves an empty result register and a core ready for requests.
   `PIDPC_ASSERT_NORST(a_reset_state, clock, reset |=> !rsp_valid && req_ready, "wrong port state after reset")

endmodule

bind pid_position_controller_top pidpc_checker u_pidpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready)
);

>>> test/pid_position_controller_top_tb.sv
// Self-checking testbench of pid_position_controller_top: drives ticks over the request
// channel, predicts each drive, position and retract flag, and checks every result.
// Depends on pidpc_pkg, pidpc_if and the controller RTL.
module pid_position_controller_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pidpc_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 80;
   localparam int REPORT_LIMIT = 200;
   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] drive;
      logic [POS_WIDTH-1:0]         position;
      logic                         retract;
   } tick_result_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   pidpc_req_if req_ch();
   pidpc_rsp_if rsp_ch();

   pid_position_controller_top uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Controller state and register copies kept by the predictor.
   longint cfg_kp, cfg_ki, cfg_kd, cfg_dt, cfg_inv_dt;
   longint loop_integral, loop_prev_error, loop_last_drive;

   tick_result_type pending_ticks[$];
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int error_count = 0;
   int report_lines = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_word(input longint x);
      if (x > WORD_MAX) return WORD_MAX;
      if (x < WORD_MIN) return WORD_MIN;
      return x;
   endfunction

   // Fixed-point product, floored to FRAC_BITS fraction bits and saturated.
   function automatic longint scaled_product(input longint a, input longint b);
      logic        neg;
      logic [47:0] ua;
      logic [31:0] ub;
      logic [79:0] prod;
      logic [79:0] q;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? 48'(-a) : 48'(a);
      ub = (b < 0) ? 32'(-b) : 32'(b);
      prod = ua * ub;
      q = prod >> FRAC_BITS;
      if (neg) begin
         if (prod[FRAC_BITS-1:0] != 0) q = q + 1;
         if (q > 80'h80000000) return WORD_MIN;
         return -longint'(q[63:0]);
      end
      if (q > 80'h7FFFFFFF) return WORD_MAX;
      return longint'(q[63:0]);
   endfunction

   function automatic longint volts_to_fraction(input logic [VOLTS_WIDTH-1:0] raw);
      if (raw < 16'd8192) return 0;
      if (raw > 16'd32768) return 64'sd65536;
      return ((4 * longint'(raw) + 8192) << FRAC_BITS) / 409600;
   endfunction

   function automatic tick_result_type advance_loop(input logic [SETPOINT_WIDTH-1:0] setpoint,
                                                    input logic [VOLTS_WIDTH-1:0] volts);
      longint          pos, err, deriv, drive;
      tick_result_type r;
      pos = volts_to_fraction(volts);
      err = clamp_word(longint'(setpoint) - pos);
      loop_integral = clamp_word(loop_integral + scaled_product(err, cfg_dt));
      deriv = scaled_product(err - loop_prev_error, cfg_inv_dt);
      drive = clamp_word(scaled_product(err, cfg_kp) + scaled_product(loop_integral, cfg_ki)
                         + scaled_product(deriv, cfg_kd));
      loop_prev_error = err;
      r.drive = drive[DATA_WIDTH-1:0];
      r.position = pos[POS_WIDTH-1:0];
      r.retract = drive < loop_last_drive;
      loop_last_drive = drive;
      return r;
   endfunction

   function automatic void check_field(input string field, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
      if (want !== got) begin
         error_count++;
         if (report_lines < REPORT_LIMIT) begin
            report_lines++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         end
      end
   endfunction

   // Sends one request, idling first as the current sender setting asks, and
   // records the predicted result once the request is taken.
   task automatic send_tick(input logic [SETPOINT_WIDTH-1:0] setpoint,
                            input logic [VOLTS_WIDTH-1:0] volts);
      if (send_idle_pct > 0 && $urandom_range(24) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 100)) @(posedge clock);
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.setpoint <= setpoint;
      req_ch.sensor_volts <= volts;
      do @(posedge clock); while (!req_ch.ready);
      pending_ticks.push_back(advance_loop(setpoint, volts));
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_ticks.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_GAIN_P:    cfg_kp = longint'($signed(data));
         CSR_GAIN_I:    cfg_ki = longint'($signed(data));
         CSR_GAIN_D:    cfg_kd = longint'($signed(data));
         CSR_STEP_TIME: cfg_dt = longint'(data[STEP_WIDTH-1:0]);
         CSR_INV_STEP:  cfg_inv_dt = longint'(data[STEP_WIDTH-1:0]);
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [31:0] kp, input logic [31:0] ki,
                               input logic [31:0] kd, input logic [31:0] dt,
                               input logic [31:0] inv_dt);
      write_register(CSR_GAIN_P, kp);
      write_register(CSR_GAIN_I, ki);
      write_register(CSR_GAIN_D, kd);
      write_register(CSR_STEP_TIME, dt);
      write_register(CSR_INV_STEP, inv_dt);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(4))
         0, 1: return $urandom_range(0, 131072);
         2: return 32'($urandom_range(0, 262144)) - 32'd131072;
         3: return $urandom;
         default: begin
            case ($urandom_range(2))
               0: return 32'h7FFFFFFF;
               1: return 32'h80000000;
               default: return 32'd0;
            endcase
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_step(input int unsigned ceiling);
      case ($urandom_range(3))
         0, 1: return $urandom_range(1, ceiling);
         2: return $urandom >> 1;
         default: return $urandom_range(1) ? 32'h7FFFFFFF : 32'd0;
      endcase
   endfunction

   // Ticks come in runs around one operating point so that the integral can
   // build up and saturate; the points favor the sensor window and its edges.
   task automatic run_random(input int count);
      int                        sent;
      int                        run_len;
      logic [SETPOINT_WIDTH-1:0] sp_base;
      logic [VOLTS_WIDTH-1:0]    v_base;
      sent = 0;
      while (sent < count) begin
         sp_base = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
         case ($urandom_range(3))
            0: v_base = 16'($urandom);
            1: v_base = $urandom_range(1) ? 16'($urandom_range(8100, 8300))
                                          : 16'($urandom_range(32700, 32850));
            default: v_base = 16'($urandom_range(8192, 32768));
         endcase
         run_len = $urandom_range(1, 16);
         repeat (run_len) begin
            if (sent < count) begin
               send_tick(sp_base + 17'($urandom_range(0, 3)), v_base + 16'($urandom_range(0, 3)));
               sent++;
            end
         end
      end
   endtask

   task automatic test_sensor_conversion();
      logic [VOLTS_WIDTH-1:0] volts_points[10];
      volts_points = '{16'd0, 16'd1, 16'd8191, 16'd8192, 16'd8193, 16'd20000,
                       16'd32767, 16'd32768, 16'd32769, 16'd65535};
      foreach (volts_points[i]) send_tick(17'd32768, volts_points[i]);
   endtask

   // Setpoints past 1.0 are used as given; the jumps also exercise the derivative.
   task automatic test_setpoint_range();
      send_tick(17'd0, 16'd20480);
      send_tick(17'd65536, 16'd20480);
      send_tick(17'd131071, 16'd20480);
      send_tick(17'd1, 16'd20480);
      send_tick(17'd0, 16'd20480);
   endtask

   task automatic test_gain_extremes();
      drain_results();
      apply_config(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      repeat (3) send_tick(17'd131071, 16'd0);
      repeat (3) send_tick(17'd0, 16'd65535);
      drain_results();
      // Zero step times keep the integral from changing and the derivative term at zero.
      apply_config(32'h80000000, 32'h80000000, 32'h80000000, 32'd0, 32'd0);
      repeat (2) send_tick(17'd131071, 16'd0);
      repeat (2) send_tick(17'd0, 16'd65535);
      drain_results();
      apply_config(32'hFFFFFFFF, 32'd1, 32'hFFFFFFFF, 32'd1, 32'd3);
      send_tick(17'd65536, 16'd8192);
      send_tick(17'd12345, 16'd32768);
   endtask

   task automatic test_random_traffic();
      int idle_table[4];
      int stall_table[4];
      idle_table = '{0, 63, 0, 6};
      stall_table = '{0, 0, 63, 6};
      for (int mode = 0; mode < 4; mode++) begin
         for (int chunk = 0; chunk < 3; chunk++) begin
            drain_results();
            send_idle_pct = idle_table[mode];
            rsp_stall_pct = stall_table[mode];
            apply_config(pick_gain(), pick_gain(), pick_gain(),
                         pick_step(65536), pick_step(16777216));
            run_random(104);
         end
      end
   endtask

   always @(posedge clock) begin : check_results
      tick_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_ticks.size() == 0) begin
            error_count++;
            if (report_lines < REPORT_LIMIT) begin
               report_lines++;
               $display("%0t: result with no request waiting: expected none, actual drive %0d",
                        $time, rsp_ch.drive);
            end
         end else begin
            want = pending_ticks.pop_front();
            check_field("drive", want.drive, rsp_ch.drive);
            check_field("measured_position", want.position, rsp_ch.measured_position);
            check_field("retract", want.retract, rsp_ch.retract);
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_GAIN_P;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.setpoint <= '0;
      req_ch.sensor_volts <= '0;
      cfg_kp = longint'(GAIN_P_RESET);
      cfg_ki = longint'(GAIN_I_RESET);
      cfg_kd = longint'(GAIN_D_RESET);
      cfg_dt = longint'(STEP_TIME_RESET);
      cfg_inv_dt = longint'(INV_STEP_RESET);
      loop_integral = 0;
      loop_prev_error = 0;
      loop_last_drive = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_sensor_conversion();
      test_setpoint_range();
      test_gain_extremes();
      test_random_traffic();

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
